>>> rtl/sha1_pkg.sv
// Package for the SHA-1 stream hasher: payload structs, controller states,
// command struct and a round helper function. No dependencies.
package sha1_pkg;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_LEN,
      ST_EMIT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic       put_byte;   // write byte_val at fill pointer
      logic [7:0] byte_val;
      logic       add_bits;   // bit count += 8
      logic       start_blk;  // load working words from chain
      logic       do_round;
      logic       fold;       // add working words into chain
      logic       init;       // return to initial values
      logic       latch_len;  // capture bit count for padding
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic [6:0] round;
      logic [7:0] len_byte;   // length byte at current fill position
   } status_type;

   function automatic logic [31:0] rotl1(input logic [31:0] x);
      return {x[30:0], x[31]};
   endfunction

endpackage

>>> rtl/sha1_datapath.sv
// SHA-1 datapath: schedule words (which also hold the incoming block bytes),
// working and chaining words. Depends on sha1_pkg.
module sha1_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha1_pkg::cmd_type      cmd,
   input  logic [2:0]             emit_idx,
   output sha1_pkg::status_type   status,
   output logic [31:0]            chain_word
);

   logic [31:0] w_ff [16];
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [63:0] bits_ff, len_ff;
   logic [5:0]  fill_ff, fill_in;
   logic [6:0]  round_ff, round_in;
   logic [3:0]  ri;
   logic [31:0] wt, wn, f, k;
   logic [2:0]  lsel;

   assign ri = round_ff[3:0];
   assign wn = sha1_pkg::rotl1(w_ff[4'(ri + 4'd13)] ^ w_ff[4'(ri + 4'd8)]
                               ^ w_ff[4'(ri + 4'd2)] ^ w_ff[ri]);
   assign wt = (round_ff < 7'd16) ? w_ff[ri] : wn;
   assign lsel = 3'(fill_ff[2:0]);

   always_comb begin
      if (round_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = sha1_pkg::K0;
      end else if (round_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = sha1_pkg::K1;
      end else if (round_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = sha1_pkg::K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = sha1_pkg::K3;
      end
      fill_in = fill_ff;
      if (cmd.put_byte) fill_in = 6'(fill_ff + 6'd1);
      if (cmd.init) fill_in = '0;
      round_in = round_ff;
      if (cmd.start_blk) round_in = '0;
      else if (cmd.do_round) round_in = 7'(round_ff + 7'd1);
      h_in[0] = h_ff[0] + a_ff;
      h_in[1] = h_ff[1] + b_ff;
      h_in[2] = h_ff[2] + c_ff;
      h_in[3] = h_ff[3] + d_ff;
      h_in[4] = h_ff[4] + e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         round_ff <= '0;
         bits_ff <= '0;
         h_ff <= '{sha1_pkg::IV0, sha1_pkg::IV1, sha1_pkg::IV2,
                   sha1_pkg::IV3, sha1_pkg::IV4};
      end else begin
         fill_ff <= fill_in;
         round_ff <= round_in;
         if (cmd.add_bits) bits_ff <= bits_ff + 64'd8;
         if (cmd.fold) h_ff <= h_in;
         if (cmd.init) begin
            bits_ff <= '0;
            h_ff <= '{sha1_pkg::IV0, sha1_pkg::IV1, sha1_pkg::IV2,
                      sha1_pkg::IV3, sha1_pkg::IV4};
         end
      end
   end

   // Bytes land directly in the schedule words, most significant byte first.
   // No byte is taken while rounds run, so the schedule doubles as the buffer.
   always_ff @(posedge clock) begin
      if (cmd.put_byte) w_ff[fill_ff[5:2]][8*(2'd3 - fill_ff[1:0]) +: 8] <= cmd.byte_val;
      if (cmd.latch_len) len_ff <= bits_ff;
      if (cmd.start_blk) begin
         a_ff <= h_ff[0];
         b_ff <= h_ff[1];
         c_ff <= h_ff[2];
         d_ff <= h_ff[3];
         e_ff <= h_ff[4];
      end else if (cmd.do_round) begin
         if (round_ff >= 7'd16) w_ff[ri] <= wn;
         a_ff <= {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + wt;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   assign status.fill = fill_ff;
   assign status.round = round_ff;
   assign status.len_byte = len_ff[8*(3'd7 - lsel) +: 8];
   assign chain_word = (emit_idx < 3'd5) ? h_ff[emit_idx] : '0;

endmodule

>>> rtl/sha1_controller.sv
// SHA-1 controller: sequences absorb, padding, block rounds and digest emit.
// Depends on sha1_pkg.
module sha1_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sha1_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             emit_idx,
   input  sha1_pkg::status_type   status,
   output sha1_pkg::cmd_type      cmd
);

   sha1_pkg::state_type state_ff, state_in;
   sha1_pkg::state_type ret_ff, ret_in;
   logic [2:0] idx_ff, idx_in;
   logic       blk_go;
   logic       entered_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1_pkg::ST_IDLE;
         ret_ff <= sha1_pkg::ST_IDLE;
         idx_ff <= '0;
         entered_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         idx_ff <= idx_in;
         entered_ff <= blk_go;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      idx_in = idx_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      blk_go = 1'b0;
      case (state_ff)
         sha1_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.put_byte = 1'b1;
               if (req_data.command == sha1_pkg::CMD_ABSORB) begin
                  cmd.byte_val = req_data.data_byte;
                  cmd.add_bits = 1'b1;
                  ret_in = sha1_pkg::ST_IDLE;
               end else begin
                  cmd.byte_val = sha1_pkg::PAD_MARK;
                  cmd.latch_len = 1'b1;
                  ret_in = sha1_pkg::ST_PAD;
                  state_in = sha1_pkg::ST_PAD;
               end
               blk_go = (status.fill == 6'd63);
            end
         end
         sha1_pkg::ST_PAD: begin
            if (status.fill == sha1_pkg::LEN_POS) begin
               state_in = sha1_pkg::ST_LEN;
            end else begin
               cmd.put_byte = 1'b1;
               blk_go = (status.fill == 6'd63);
            end
         end
         sha1_pkg::ST_LEN: begin
            cmd.put_byte = 1'b1;
            cmd.byte_val = status.len_byte;
            if (status.fill == 6'd63) begin
               blk_go = 1'b1;
               ret_in = sha1_pkg::ST_EMIT;
            end
         end
         sha1_pkg::ST_ROUND: begin
            if (status.round == 7'd80) begin
               cmd.fold = 1'b1;
               state_in = ret_ff;
               idx_in = '0;
            end else begin
               cmd.do_round = 1'b1;
            end
         end
         sha1_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = 3'(idx_ff + 3'd1);
               if (idx_ff == 3'd4) begin
                  cmd.init = 1'b1;
                  state_in = sha1_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha1_pkg::ST_IDLE;
      endcase
      if (blk_go) state_in = sha1_pkg::ST_ROUND;
      // The first cycle in the round state loads the working words; the round
      // counter still holds its old value then, so nothing else may fire.
      if (entered_ff) begin
         cmd.start_blk = 1'b1;
         cmd.do_round = 1'b0;
         cmd.fold = 1'b0;
         state_in = sha1_pkg::ST_ROUND;
         idx_in = idx_ff;
      end
   end

   assign emit_idx = idx_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> idx_ff <= 3'd4) else $error("emit index out of range");
   assert property (@(posedge clock) disable iff (reset)
      (req_ready && rsp_valid) == 1'b0) else $error("input taken while emitting");
   assert property (@(posedge clock) disable iff (reset)
      entered_ff |-> state_ff == sha1_pkg::ST_ROUND) else $error("block start lost");

endmodule

>>> rtl/sha1_stream_hasher_core.sv
// Top level of the SHA-1 stream hasher: controller plus datapath.
// Depends on sha1_pkg, sha1_controller, sha1_datapath.
//
//   channel | direction | payload
//   req     | in        | command, data_byte
//   rsp     | out       | digest_word, word_index, last_word
//
// An absorb item that completes a block starts it: a load of the working words,
// 80 rounds on the single round unit, then a fold; req is not taken meanwhile.
// Finish pads one byte per cycle outside rounds, runs 1-2 blocks, emits 5 items.
// Reset is synchronous and restores the initial chaining values.
// A stalled rsp holds the current digest word; req is not taken meanwhile.
module sha1_stream_hasher_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha1_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha1_pkg::rsp_type   rsp_data
);

   sha1_pkg::cmd_type    cmd;
   sha1_pkg::status_type status;
   logic [2:0]           emit_idx;
   logic [31:0]          chain_word;

   sha1_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .emit_idx, .status, .cmd
   );

   sha1_datapath u_dp (
      .clock, .reset, .cmd, .emit_idx, .status, .chain_word
   );

   assign rsp_data.digest_word = chain_word;
   assign rsp_data.word_index = emit_idx;
   assign rsp_data.last_word = (emit_idx == 3'd4);

endmodule
